### rtl/esd_pkg.sv
// Shared types and character codes for the escape sequence decoder.
`default_nettype none

package esd_pkg;

    localparam int CODE_W  = 16;
    localparam int VAL_W   = 10;
    localparam int MAX_OUT = 3;

    // parse modes
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_ESC   = 2'd1;
    localparam logic [1:0] MODE_HEX   = 2'd2;
    localparam logic [1:0] MODE_DEC   = 2'd3;

    localparam logic [CODE_W-1:0] CH_BSLASH = 16'h005C;
    localparam logic [CODE_W-1:0] CH_DQUOTE = 16'h0022;
    localparam logic [CODE_W-1:0] CH_QUOTE  = 16'h0027;
    localparam logic [CODE_W-1:0] CH_X      = 16'h0078;
    localparam logic [CODE_W-1:0] CH_A      = 16'h0061;
    localparam logic [CODE_W-1:0] CH_B      = 16'h0062;
    localparam logic [CODE_W-1:0] CH_F      = 16'h0066;
    localparam logic [CODE_W-1:0] CH_N      = 16'h006E;
    localparam logic [CODE_W-1:0] CH_R      = 16'h0072;
    localparam logic [CODE_W-1:0] CH_T      = 16'h0074;
    localparam logic [CODE_W-1:0] CH_0      = 16'h0030;
    localparam logic [CODE_W-1:0] CH_9      = 16'h0039;
    localparam logic [CODE_W-1:0] CH_UC_A   = 16'h0041;
    localparam logic [CODE_W-1:0] CH_UC_F   = 16'h0046;

    localparam logic [CODE_W-1:0] CTL_BEL = 16'd7;
    localparam logic [CODE_W-1:0] CTL_BS  = 16'd8;
    localparam logic [CODE_W-1:0] CTL_FF  = 16'd12;
    localparam logic [CODE_W-1:0] CTL_LF  = 16'd10;
    localparam logic [CODE_W-1:0] CTL_CR  = 16'd13;
    localparam logic [CODE_W-1:0] CTL_TAB = 16'd9;

    typedef struct packed {
        logic [CODE_W-1:0] char_code;
        logic              final_char;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] out_code;
        logic              final_out;
    } out_item_t;

    // results of one input item, entry 0 goes out first
    typedef struct packed {
        logic [MAX_OUT-1:0][CODE_W-1:0] codes;
        logic [1:0]                     count;
        logic                           last;
    } esd_group_t;

endpackage

`default_nettype wire

### rtl/esd_stream_if.sv
// Valid/ready stream interface carrying one payload per transaction.
`default_nettype none

interface esd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/esd_decode.sv
// Parse state and single-pass decode of one character into up to three results.
`default_nettype none

module esd_decode (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire logic [esd_pkg::CODE_W-1:0] char_code,
    input  wire logic                       final_char,
    output esd_pkg::esd_group_t             group
);

    logic [1:0]                   mode_reg, mode_next;
    logic [1:0]                   cnt_reg, cnt_next;
    logic [esd_pkg::VAL_W-1:0]    val_reg, val_next;

    logic                         is_dec;
    logic                         is_hex;
    logic [3:0]                   hex_digit;
    logic [esd_pkg::VAL_W-1:0]    hex_acc;
    logic [esd_pkg::VAL_W-1:0]    dec_acc;
    logic [esd_pkg::CODE_W-1:0]   val_code;

    always_comb
    begin
        is_dec    = (char_code >= esd_pkg::CH_0) && (char_code <= esd_pkg::CH_9);
        is_hex    = 1'b1;
        hex_digit = 4'd0;
        if (is_dec)
        begin
            hex_digit = char_code[3:0];
        end
        else if ((char_code >= esd_pkg::CH_A) && (char_code <= esd_pkg::CH_F))
        begin
            hex_digit = char_code[3:0] + 4'd9;
        end
        else if ((char_code >= esd_pkg::CH_UC_A) && (char_code <= esd_pkg::CH_UC_F))
        begin
            hex_digit = char_code[3:0] + 4'd9;
        end
        else
        begin
            is_hex = 1'b0;
        end
        // value*16 + digit and value*10 + digit, kept to 10 bits
        hex_acc  = {val_reg[5:0], hex_digit};
        dec_acc  = {val_reg[6:0], 3'b000} + {val_reg[8:0], 1'b0}
                 + {6'd0, char_code[3:0]};
        val_code = {{(esd_pkg::CODE_W-esd_pkg::VAL_W){1'b0}}, val_reg};
    end

    always_comb
    begin
        logic [1:0]                      n;
        logic                            take_plain;
        logic [esd_pkg::VAL_W-1:0]       flush_val;

        n          = 2'd0;
        take_plain = 1'b0;
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        val_next   = val_reg;
        group      = '0;
        flush_val  = val_reg;

        case (mode_reg)
            esd_pkg::MODE_PLAIN:
            begin
                take_plain = 1'b1;
            end
            esd_pkg::MODE_ESC:
            begin
                mode_next = esd_pkg::MODE_PLAIN;
                case (char_code)
                    esd_pkg::CH_A: begin group.codes[n] = esd_pkg::CTL_BEL; n = n + 2'd1; end
                    esd_pkg::CH_B: begin group.codes[n] = esd_pkg::CTL_BS;  n = n + 2'd1; end
                    esd_pkg::CH_F: begin group.codes[n] = esd_pkg::CTL_FF;  n = n + 2'd1; end
                    esd_pkg::CH_N: begin group.codes[n] = esd_pkg::CTL_LF;  n = n + 2'd1; end
                    esd_pkg::CH_R: begin group.codes[n] = esd_pkg::CTL_CR;  n = n + 2'd1; end
                    esd_pkg::CH_T: begin group.codes[n] = esd_pkg::CTL_TAB; n = n + 2'd1; end
                    esd_pkg::CH_DQUOTE, esd_pkg::CH_QUOTE, esd_pkg::CH_BSLASH:
                    begin
                        group.codes[n] = char_code;
                        n = n + 2'd1;
                    end
                    esd_pkg::CH_X:
                    begin
                        mode_next = esd_pkg::MODE_HEX;
                        cnt_next  = 2'd0;
                        val_next  = '0;
                    end
                    default:
                    begin
                        if (is_dec)
                        begin
                            mode_next = esd_pkg::MODE_DEC;
                            cnt_next  = 2'd1;
                            val_next  = {6'd0, char_code[3:0]};
                        end
                        else
                        begin
                            group.codes[n] = esd_pkg::CH_BSLASH;
                            n = n + 2'd1;
                            group.codes[n] = char_code;
                            n = n + 2'd1;
                        end
                    end
                endcase
            end
            esd_pkg::MODE_HEX:
            begin
                if (is_hex)
                begin
                    val_next = hex_acc;
                    cnt_next = cnt_reg + 2'd1;
                    if (cnt_next >= 2'd2)
                    begin
                        group.codes[n] = {{(esd_pkg::CODE_W-esd_pkg::VAL_W){1'b0}}, hex_acc};
                        n = n + 2'd1;
                        mode_next = esd_pkg::MODE_PLAIN;
                    end
                end
                else
                begin
                    if (cnt_reg == 2'd0)
                    begin
                        group.codes[n] = esd_pkg::CH_BSLASH;
                        n = n + 2'd1;
                        group.codes[n] = esd_pkg::CH_X;
                        n = n + 2'd1;
                    end
                    else
                    begin
                        group.codes[n] = val_code;
                        n = n + 2'd1;
                    end
                    take_plain = 1'b1;
                end
            end
            default:
            begin
                if (is_dec)
                begin
                    val_next = dec_acc;
                    cnt_next = cnt_reg + 2'd1;
                    if (cnt_next >= 2'd3)
                    begin
                        group.codes[n] = {{(esd_pkg::CODE_W-esd_pkg::VAL_W){1'b0}}, dec_acc};
                        n = n + 2'd1;
                        mode_next = esd_pkg::MODE_PLAIN;
                    end
                end
                else
                begin
                    group.codes[n] = val_code;
                    n = n + 2'd1;
                    take_plain = 1'b1;
                end
            end
        endcase

        if (take_plain)
        begin
            if (char_code == esd_pkg::CH_BSLASH)
            begin
                mode_next = esd_pkg::MODE_ESC;
            end
            else
            begin
                mode_next = esd_pkg::MODE_PLAIN;
                group.codes[n] = char_code;
                n = n + 2'd1;
            end
        end

        // end of text: flush whatever escape is still open
        if (final_char)
        begin
            flush_val = val_next;
            case (mode_next)
                esd_pkg::MODE_ESC:
                begin
                    group.codes[n] = esd_pkg::CH_BSLASH;
                    n = n + 2'd1;
                end
                esd_pkg::MODE_HEX:
                begin
                    if (cnt_next == 2'd0)
                    begin
                        group.codes[n] = esd_pkg::CH_BSLASH;
                        n = n + 2'd1;
                        group.codes[n] = esd_pkg::CH_X;
                        n = n + 2'd1;
                    end
                    else
                    begin
                        group.codes[n] = {{(esd_pkg::CODE_W-esd_pkg::VAL_W){1'b0}}, flush_val};
                        n = n + 2'd1;
                    end
                end
                esd_pkg::MODE_DEC:
                begin
                    group.codes[n] = {{(esd_pkg::CODE_W-esd_pkg::VAL_W){1'b0}}, flush_val};
                    n = n + 2'd1;
                end
                default:
                begin
                end
            endcase
            mode_next = esd_pkg::MODE_PLAIN;
            cnt_next  = 2'd0;
            val_next  = '0;
        end

        group.count = n;
        group.last  = final_char;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= esd_pkg::MODE_PLAIN;
            cnt_reg  <= 2'd0;
            val_reg  <= '0;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            val_reg  <= val_next;
        end
    end

endmodule

`default_nettype wire

### rtl/esd_serializer.sv
// Result register: holds one item's results and sends them one per transaction.
`default_nettype none

module esd_serializer (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire esd_pkg::esd_group_t  group,
    output logic                      can_load,
    esd_stream_if.source              results
);

    logic [esd_pkg::MAX_OUT-1:0][esd_pkg::CODE_W-1:0] codes_reg;
    logic [1:0]                                       remain_reg;
    logic                                             last_reg;
    logic                                             fire;

    assign fire     = results.valid && results.ready;
    assign can_load = (remain_reg == 2'd0) || ((remain_reg == 2'd1) && results.ready);

    assign results.valid             = (remain_reg != 2'd0);
    assign results.payload.out_code  = codes_reg[0];
    assign results.payload.final_out = last_reg && (remain_reg == 2'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= 2'd0;
        end
        else if (load)
        begin
            remain_reg <= group.count;
        end
        else if (fire)
        begin
            remain_reg <= remain_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            codes_reg <= group.codes;
            last_reg  <= group.last;
        end
        else if (fire)
        begin
            codes_reg[0] <= codes_reg[1];
            codes_reg[1] <= codes_reg[2];
        end
    end

endmodule

`default_nettype wire

### rtl/escape_sequence_decoder_top.sv
// Top level of the escape sequence decoder: input register, decode, result register.
`default_nettype none

// Unescapes C-style text arriving one 16-bit code unit per transaction, with
// final_char on the last unit; results leave one code unit per transaction and
// the last result of a text carries final_out. A new unit is taken every cycle
// while each unit yields at most one result and the results are accepted. The
// result register drains one result per cycle while the results are accepted,
// so a unit that yields two or three results (unknown escapes, a bare \x, a
// numeric escape cut short, end-of-text flushes) holds the input side until its
// last result is being sent. An input transaction reaches the results through
// the input register and then the result register.
module escape_sequence_decoder_top (
    input  wire logic    clk,
    input  wire logic    rst_n,
    esd_stream_if.sink   chars,
    esd_stream_if.source results
);

    logic                          in_valid_reg;
    logic [esd_pkg::CODE_W-1:0]    in_char_reg;
    logic                          in_final_reg;
    logic                          can_load;
    logic                          advance;
    esd_pkg::esd_group_t           group;

    assign advance     = in_valid_reg && can_load;
    assign chars.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (chars.valid && chars.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            in_char_reg  <= chars.payload.char_code;
            in_final_reg <= chars.payload.final_char;
        end
    end

    esd_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .char_code  (in_char_reg),
        .final_char (in_final_reg),
        .group      (group)
    );

    esd_serializer u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .group    (group),
        .can_load (can_load),
        .results  (results)
    );

endmodule

`default_nettype wire
